// ===== sv/pic_pkg.sv =====
// shared types, codes and helpers of the prefix instruction cpu core
// no dependencies; the design files refer to it by scoped names, the bench imports it
`default_nettype none

package pic_pkg;

  localparam int unsigned MEM_WORDS_DEF = 65536;

  // request kinds
  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_STEP  = 2'd1;
  localparam logic [1:0] K_REPLY = 2'd2;
  localparam logic [1:0] K_READ  = 2'd3;

  // opcodes (high nibble)
  localparam logic [3:0] OP_LDAM = 4'h0;
  localparam logic [3:0] OP_LDBM = 4'h1;
  localparam logic [3:0] OP_STAM = 4'h2;
  localparam logic [3:0] OP_LDAC = 4'h3;
  localparam logic [3:0] OP_LDBC = 4'h4;
  localparam logic [3:0] OP_LDAP = 4'h5;
  localparam logic [3:0] OP_LDAI = 4'h6;
  localparam logic [3:0] OP_LDBI = 4'h7;
  localparam logic [3:0] OP_STAI = 4'h8;
  localparam logic [3:0] OP_BR   = 4'h9;
  localparam logic [3:0] OP_BRZ  = 4'hA;
  localparam logic [3:0] OP_BRN  = 4'hB;
  localparam logic [3:0] OP_OPR  = 4'hC;
  localparam logic [3:0] OP_PFIX = 4'hD;
  localparam logic [3:0] OP_NFIX = 4'hE;
  localparam logic [3:0] OP_NOP  = 4'hF;

  // operate codes
  localparam logic [31:0] OPR_ADD = 32'd0;
  localparam logic [31:0] OPR_SUB = 32'd1;
  localparam logic [31:0] OPR_BRB = 32'd2;
  localparam logic [31:0] OPR_SVC = 32'd3;

  // service call selectors in A
  localparam logic [31:0] SVC_EXIT = 32'd0;
  localparam logic [31:0] SVC_OUT  = 32'd1;
  localparam logic [31:0] SVC_IN   = 32'd2;

  // service events
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_EXIT = 2'd1;
  localparam logic [1:0] EV_OUT  = 2'd2;
  localparam logic [1:0] EV_IN   = 2'd3;

  localparam logic [31:0] NFIX_MASK = 32'hFFFFFF00;
  localparam logic [31:0] SP_WORD   = 32'd1;

  // what a pending memory access is for
  typedef enum logic [3:0] {
    P_LOAD,
    P_READ,
    P_FETCH,
    P_RDA,
    P_RDB,
    P_WRA,
    P_SP,
    P_OBYTE,
    P_OCHAN,
    P_ICHAN,
    P_TARGET
  } purp_e;

  typedef struct packed {
    logic  start;
    purp_e tag;
  } wrap_req_t;

  typedef struct packed {
    logic  done;
    purp_e tag;
  } wrap_rsp_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word_address;
    logic [31:0] word_data;
    logic [7:0]  reply_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] program_counter;
    logic [31:0] accumulator_a;
    logic [31:0] accumulator_b;
    logic [7:0]  fetched_byte;
    logic [1:0]  service_event;
    logic [3:0]  io_channel;
    logic [7:0]  output_byte;
    logic [31:0] read_word;
    logic        awaiting_input;
  } out_t;

  // io channel from a selector word
  function automatic logic [3:0] chan_of(input logic [31:0] sel);
    logic [3:0] ch;
    if (sel[31] || (sel < 32'd256)) begin
      ch = 4'd0;
    end else begin
      ch = {1'b0, sel[10:8]} + 4'd1;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pic_if.sv =====
// valid/ready channels carrying the request and result payloads
// depends on pic_pkg for the payload structs
`default_nettype none

interface pic_in_if;
  logic          valid;
  logic          ready;
  pic_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pic_out_if;
  logic          valid;
  logic          ready;
  pic_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/prefix_instruction_cpu_core_unit.sv =====
// Accumulator processor with prefix instructions, executing from a word memory.
// Requests enter on in_i (valid/ready); every request yields exactly one result
// on out_o. Kinds: load a memory word, execute one instruction, deliver an input
// reply byte, read a memory word. Results carry pc, A, B and per-request fields.
// The single-port memory with its registered read sets the pace: each memory read a
// request needs (instruction fetch, data load, stack pointer and stack words) adds a
// pass through the data state; writes ride on the address cycle. A new request is
// accepted only when idle. A memory load instruction fetches, then reads; an input
// service call reads the stack pointer, then the channel word; an output call reads
// the stack pointer, the output byte word, then the channel word. Memory sizes that
// are not a power of two reduce addresses through a registered pipeline.
// Reset clears pc, A, B, the operand and the pending-input flag; memory is not
// cleared and holds nothing until written. The result sits in an output
// register; while the receiver stalls the next request is still accepted and
// worked on, and its result waits until the register is taken.
// depends on pic_pkg, pic_if, pic_mem and pic_wrap
`default_nettype none

module prefix_instruction_cpu_core_unit #(
  parameter int unsigned MEM_WORDS = pic_pkg::MEM_WORDS_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  pic_in_if.sink   in_i,
  pic_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WRAP = 2'd1;
  localparam logic [1:0] S_MEMD = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]     state_q, state_d;
  pic_pkg::purp_e purp_q, purp_d;
  logic [31:0]    pc_q, pc_d, a_q, a_d, b_q, b_d, opr_q, opr_d;
  logic           pend_q, pend_d;
  logic [AW-1:0]  tgt_q, tgt_d;
  logic [31:0]    sp_q, sp_d, ldata_q, ldata_d, rword_q, rword_d;
  logic [7:0]     fetched_q, fetched_d, obyte_q, obyte_d;
  logic [1:0]     event_q, event_d;
  logic [3:0]     chan_q, chan_d;
  logic           ovalid_q, ovalid_d;
  pic_pkg::out_t  out_q, out_d;

  pic_pkg::wrap_req_t wreq;
  pic_pkg::wrap_rsp_t wrsp;
  logic [31:0]        wx;
  logic [AW-1:0]      widx;

  pic_pkg::mem_ctl_t  mctl;
  logic [AW-1:0]      maddr;
  logic [31:0]        mwdata, mrdata;

  logic               accept;
  logic [7:0]         inst;
  logic [31:0]        op_n, pc_n;

  pic_wrap #(.MEM_WORDS(MEM_WORDS)) u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (wreq),
    .x_i    (wx),
    .rsp_o  (wrsp),
    .idx_o  (widx)
  );

  pic_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mctl),
    .addr_i  (maddr),
    .wdata_i (mwdata),
    .rdata_o (mrdata)
  );

  assign in_i.ready    = (state_q == S_IDLE);
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = ovalid_q;
  assign out_o.payload = out_q;

  always_comb begin
    case (pc_q[1:0])
      2'd0:    inst = mrdata[7:0];
      2'd1:    inst = mrdata[15:8];
      2'd2:    inst = mrdata[23:16];
      default: inst = mrdata[31:24];
    endcase
  end

  assign op_n = opr_q | {28'd0, inst[3:0]};
  assign pc_n = pc_q + 32'd1;

  always_comb begin
    state_d   = state_q;
    purp_d    = purp_q;
    pc_d      = pc_q;
    a_d       = a_q;
    b_d       = b_q;
    opr_d     = opr_q;
    pend_d    = pend_q;
    tgt_d     = tgt_q;
    sp_d      = sp_q;
    ldata_d   = ldata_q;
    rword_d   = rword_q;
    fetched_d = fetched_q;
    obyte_d   = obyte_q;
    event_d   = event_q;
    chan_d    = chan_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    out_d     = out_q;
    wreq.start = 1'b0;
    wreq.tag   = pic_pkg::P_READ;
    wx         = 32'd0;
    mctl.en    = 1'b0;
    mctl.we    = 1'b0;
    maddr      = tgt_q;
    mwdata     = {24'd0, in_i.payload.reply_byte};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rword_d   = 32'd0;
          fetched_d = 8'd0;
          obyte_d   = 8'd0;
          event_d   = pic_pkg::EV_NONE;
          chan_d    = 4'd0;
          ldata_d   = in_i.payload.word_data;
          state_d   = S_OUT;
          case (in_i.payload.kind)
            pic_pkg::K_LOAD: begin
              wreq.start = 1'b1;
              wreq.tag   = pic_pkg::P_LOAD;
              wx         = {16'd0, in_i.payload.word_address};
            end
            pic_pkg::K_READ: begin
              wreq.start = 1'b1;
              wreq.tag   = pic_pkg::P_READ;
              wx         = {16'd0, in_i.payload.word_address};
            end
            pic_pkg::K_REPLY: begin
              if (pend_q) begin
                mctl.en = 1'b1;
                mctl.we = 1'b1;
                pend_d  = 1'b0;
              end
            end
            default: begin
              if (!pend_q) begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_FETCH;
                wx         = {2'd0, pc_q[31:2]};
              end
            end
          endcase
        end
      end

      S_MEMD: begin
        state_d = S_OUT;
        case (purp_q)
          pic_pkg::P_READ: rword_d = mrdata;
          pic_pkg::P_RDA:  a_d = mrdata;
          pic_pkg::P_RDB:  b_d = mrdata;
          pic_pkg::P_SP: begin
            sp_d       = mrdata;
            wreq.start = 1'b1;
            wreq.tag   = (a_q == pic_pkg::SVC_OUT) ? pic_pkg::P_OBYTE : pic_pkg::P_ICHAN;
            wx         = mrdata + 32'd2;
          end
          pic_pkg::P_OBYTE: begin
            obyte_d    = mrdata[7:0];
            wreq.start = 1'b1;
            wreq.tag   = pic_pkg::P_OCHAN;
            wx         = sp_q + 32'd3;
          end
          pic_pkg::P_OCHAN: chan_d = pic_pkg::chan_of(mrdata);
          pic_pkg::P_ICHAN: begin
            chan_d     = pic_pkg::chan_of(mrdata);
            wreq.start = 1'b1;
            wreq.tag   = pic_pkg::P_TARGET;
            wx         = sp_q + 32'd1;
          end
          pic_pkg::P_FETCH: begin
            fetched_d = inst;
            pc_d      = pc_n;
            opr_d     = 32'd0;
            case (inst[7:4])
              pic_pkg::OP_LDAM: begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_RDA;
                wx         = op_n;
              end
              pic_pkg::OP_LDBM: begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_RDB;
                wx         = op_n;
              end
              pic_pkg::OP_STAM: begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_WRA;
                wx         = op_n;
              end
              pic_pkg::OP_LDAC: a_d = op_n;
              pic_pkg::OP_LDBC: b_d = op_n;
              pic_pkg::OP_LDAP: a_d = pc_n + op_n;
              pic_pkg::OP_LDAI: begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_RDA;
                wx         = a_q + op_n;
              end
              pic_pkg::OP_LDBI: begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_RDB;
                wx         = b_q + op_n;
              end
              pic_pkg::OP_STAI: begin
                wreq.start = 1'b1;
                wreq.tag   = pic_pkg::P_WRA;
                wx         = b_q + op_n;
              end
              pic_pkg::OP_BR: pc_d = pc_n + op_n;
              pic_pkg::OP_BRZ: begin
                if (a_q == 32'd0) pc_d = pc_n + op_n;
              end
              pic_pkg::OP_BRN: begin
                if (a_q[31]) pc_d = pc_n + op_n;
              end
              pic_pkg::OP_OPR: begin
                if (op_n == pic_pkg::OPR_ADD) begin
                  a_d = a_q + b_q;
                end else if (op_n == pic_pkg::OPR_SUB) begin
                  a_d = a_q - b_q;
                end else if (op_n == pic_pkg::OPR_BRB) begin
                  pc_d = b_q;
                end else if (op_n == pic_pkg::OPR_SVC) begin
                  if (a_q == pic_pkg::SVC_EXIT) begin
                    event_d = pic_pkg::EV_EXIT;
                  end else if ((a_q == pic_pkg::SVC_OUT) || (a_q == pic_pkg::SVC_IN)) begin
                    event_d    = (a_q == pic_pkg::SVC_OUT) ? pic_pkg::EV_OUT : pic_pkg::EV_IN;
                    wreq.start = 1'b1;
                    wreq.tag   = pic_pkg::P_SP;
                    wx         = pic_pkg::SP_WORD;
                  end
                end
              end
              pic_pkg::OP_PFIX: opr_d = op_n << 4;
              pic_pkg::OP_NFIX: opr_d = pic_pkg::NFIX_MASK | (op_n << 4);
              default:          opr_d = op_n;
            endcase
          end
          default: ;
        endcase
      end

      S_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d              = 1'b1;
          out_d.program_counter = pc_q;
          out_d.accumulator_a   = a_q;
          out_d.accumulator_b   = b_q;
          out_d.fetched_byte    = fetched_q;
          out_d.service_event   = event_q;
          out_d.io_channel      = chan_q;
          out_d.output_byte     = obyte_q;
          out_d.read_word       = rword_q;
          out_d.awaiting_input  = pend_q;
          state_d               = S_IDLE;
        end
      end

      default: ;
    endcase

    // address reduction started; may complete in this same cycle
    if (wreq.start) begin
      state_d = S_WRAP;
    end

    if (wrsp.done) begin
      maddr = widx;
      case (wrsp.tag)
        pic_pkg::P_LOAD: begin
          mctl.en = 1'b1;
          mctl.we = 1'b1;
          mwdata  = (state_q == S_IDLE) ? in_i.payload.word_data : ldata_q;
          state_d = S_OUT;
        end
        pic_pkg::P_WRA: begin
          mctl.en = 1'b1;
          mctl.we = 1'b1;
          mwdata  = a_q;
          state_d = S_OUT;
        end
        pic_pkg::P_TARGET: begin
          tgt_d   = widx;
          pend_d  = 1'b1;
          state_d = S_OUT;
        end
        default: begin
          mctl.en = 1'b1;
          purp_d  = wrsp.tag;
          state_d = S_MEMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      purp_q   <= pic_pkg::P_READ;
      pc_q     <= 32'd0;
      a_q      <= 32'd0;
      b_q      <= 32'd0;
      opr_q    <= 32'd0;
      pend_q   <= 1'b0;
      tgt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      purp_q   <= purp_d;
      pc_q     <= pc_d;
      a_q      <= a_d;
      b_q      <= b_d;
      opr_q    <= opr_d;
      pend_q   <= pend_d;
      tgt_q    <= tgt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q      <= sp_d;
    ldata_q   <= ldata_d;
    rword_q   <= rword_d;
    fetched_q <= fetched_d;
    obyte_q   <= obyte_d;
    event_q   <= event_d;
    chan_q    <= chan_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/pic_mem.sv =====
// single-port word memory, registered read
// depends on pic_pkg for the control struct
`default_nettype none

module pic_mem #(
  parameter int unsigned MEM_WORDS = pic_pkg::MEM_WORDS_DEF
) (
  input  wire                          clk_i,
  input  pic_pkg::mem_ctl_t            ctl_i,
  input  wire [$clog2(MEM_WORDS)-1:0]  addr_i,
  input  wire [31:0]                   wdata_i,
  output logic [31:0]                  rdata_o
);

  logic [31:0] mem [MEM_WORDS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pic_wrap.sv =====
// reduces a 32-bit word index modulo the memory size
// power-of-two sizes mask at once, others use a reciprocal estimate and one correction
// depends on pic_pkg for the request/response structs
`default_nettype none

module pic_wrap #(
  parameter int unsigned MEM_WORDS = pic_pkg::MEM_WORDS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  pic_pkg::wrap_req_t           req_i,
  input  wire [31:0]                   x_i,
  output pic_pkg::wrap_rsp_t           rsp_o,
  output logic [$clog2(MEM_WORDS)-1:0] idx_o
);

  localparam int unsigned AW   = $clog2(MEM_WORDS);
  localparam bit          POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

  if (POW2) begin : g_mask
    assign rsp_o.done = req_i.start;
    assign rsp_o.tag  = req_i.tag;
    assign idx_o      = x_i[AW-1:0];
  end else begin : g_recip
    // quotient estimate is low by at most one, so one compare and subtract finishes
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_WORDS));
    localparam logic [31:0] MODV  = 32'(MEM_WORDS);

    logic [63:0]     prod;
    logic [31:0]     x_q, q_q, est_q, qm, fix;
    logic [AW-1:0]   rem_q;
    logic            v1_q, v2_q, done_q;
    pic_pkg::purp_e  tag_q;

    assign prod = {32'd0, x_i} * {32'd0, RECIP};
    assign qm   = q_q * MODV;
    assign fix  = (est_q >= MODV) ? (est_q - MODV) : est_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q   <= 1'b0;
        v2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        v1_q   <= req_i.start;
        v2_q   <= v1_q;
        done_q <= v2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (req_i.start) begin
        x_q   <= x_i;
        q_q   <= prod[63:32];
        tag_q <= req_i.tag;
      end
      if (v1_q) begin
        est_q <= x_q - qm;
      end
      if (v2_q) begin
        rem_q <= fix[AW-1:0];
      end
    end

    assign rsp_o.done = done_q;
    assign rsp_o.tag  = tag_q;
    assign idx_o      = rem_q;
  end

endmodule

`default_nettype wire

// ===== tb/prefix_instruction_cpu_core_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for prefix_instruction_cpu_core_unit: requests and results on
// valid/ready channels, results checked against an in-bench model of the core
// depends on pic_pkg, pic_if and the core with its memory and wrapper

module prefix_instruction_cpu_core_unit_tb;
  import pic_pkg::*;

  localparam int unsigned MEM_WORDS = MEM_WORDS_DEF;
  localparam int unsigned ITEMS = 1750;
  localparam int unsigned STUCK_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pic_in_if  in_if ();
  pic_out_if out_if ();

  prefix_instruction_cpu_core_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the core
  logic [31:0] shadow_mem [int unsigned];
  logic [15:0] written_q[$];
  logic [31:0] cpu_pc, cpu_a, cpu_b, cpu_opnd, reply_at;
  logic        cpu_wait;

  in_t  request_q[$];
  out_t core_after_q[$];

  int unsigned useful_n;
  int unsigned err_n = 0;
  int unsigned stuck_cycles = 0;
  int unsigned in_wait, out_wait;
  int unsigned in_quiet = 0;
  int unsigned out_quiet = 0;

  function automatic logic [31:0] word_of(logic [31:0] addr);
    return addr % MEM_WORDS;
  endfunction

  function automatic logic [31:0] mem_get(logic [31:0] addr);
    logic [31:0] idx;
    idx = word_of(addr);
    return shadow_mem.exists(idx) ? shadow_mem[idx] : 32'd0;
  endfunction

  function automatic void mem_put(logic [31:0] addr, logic [31:0] data);
    logic [31:0] idx;
    idx = word_of(addr);
    if (!shadow_mem.exists(idx)) written_q.push_back(idx[15:0]);
    shadow_mem[idx] = data;
  endfunction

  function automatic logic [3:0] io_channel_for(logic [31:0] sel);
    if (sel[31] || sel < 32'd256) return 4'd0;
    return 4'd1 + {1'b0, sel[10:8]};
  endfunction

  // applies one request to the model, queues the state it leaves behind;
  // returns 1 when the core ignores the request
  function automatic bit advance_core(in_t rq);
    out_t        r;
    logic [31:0] w, sp;
    logic [7:0]  ib;
    bit          ignored;
    r = '0;
    ignored = 1'b0;
    if (rq.kind == K_LOAD) begin
      mem_put({16'd0, rq.word_address}, rq.word_data);
    end else if (rq.kind == K_READ) begin
      r.read_word = mem_get({16'd0, rq.word_address});
    end else if (rq.kind == K_REPLY) begin
      if (cpu_wait) begin
        mem_put(reply_at, {24'd0, rq.reply_byte});
        cpu_wait = 1'b0;
      end else begin
        ignored = 1'b1;
      end
    end else if (cpu_wait) begin
      ignored = 1'b1;
    end else begin
      w = mem_get(cpu_pc >> 2) >> {cpu_pc[1:0], 3'b000};
      ib = w[7:0];
      r.fetched_byte = ib;
      cpu_pc = cpu_pc + 32'd1;
      cpu_opnd = cpu_opnd | {28'd0, ib[3:0]};
      case (ib[7:4])
        OP_LDAM: begin cpu_a = mem_get(cpu_opnd); cpu_opnd = '0; end
        OP_LDBM: begin cpu_b = mem_get(cpu_opnd); cpu_opnd = '0; end
        OP_STAM: begin mem_put(cpu_opnd, cpu_a); cpu_opnd = '0; end
        OP_LDAC: begin cpu_a = cpu_opnd; cpu_opnd = '0; end
        OP_LDBC: begin cpu_b = cpu_opnd; cpu_opnd = '0; end
        OP_LDAP: begin cpu_a = cpu_pc + cpu_opnd; cpu_opnd = '0; end
        OP_LDAI: begin cpu_a = mem_get(cpu_a + cpu_opnd); cpu_opnd = '0; end
        OP_LDBI: begin cpu_b = mem_get(cpu_b + cpu_opnd); cpu_opnd = '0; end
        OP_STAI: begin mem_put(cpu_b + cpu_opnd, cpu_a); cpu_opnd = '0; end
        OP_BR:   begin cpu_pc = cpu_pc + cpu_opnd; cpu_opnd = '0; end
        OP_BRZ: begin
          if (cpu_a == 32'd0) cpu_pc = cpu_pc + cpu_opnd;
          cpu_opnd = '0;
        end
        OP_BRN: begin
          if (cpu_a[31]) cpu_pc = cpu_pc + cpu_opnd;
          cpu_opnd = '0;
        end
        OP_OPR: begin
          if (cpu_opnd == OPR_ADD) begin
            cpu_a = cpu_a + cpu_b;
          end else if (cpu_opnd == OPR_SUB) begin
            cpu_a = cpu_a - cpu_b;
          end else if (cpu_opnd == OPR_BRB) begin
            cpu_pc = cpu_b;
          end else if (cpu_opnd == OPR_SVC) begin
            sp = mem_get(SP_WORD);
            if (cpu_a == SVC_EXIT) begin
              r.service_event = EV_EXIT;
            end else if (cpu_a == SVC_OUT) begin
              w = mem_get(sp + 32'd2);
              r.service_event = EV_OUT;
              r.output_byte = w[7:0];
              r.io_channel = io_channel_for(mem_get(sp + 32'd3));
            end else if (cpu_a == SVC_IN) begin
              r.service_event = EV_IN;
              r.io_channel = io_channel_for(mem_get(sp + 32'd2));
              reply_at = word_of(sp + 32'd1);
              cpu_wait = 1'b1;
            end
          end
          cpu_opnd = '0;
        end
        OP_PFIX: cpu_opnd = cpu_opnd << 4;
        OP_NFIX: cpu_opnd = NFIX_MASK | (cpu_opnd << 4);
        default: ;
      endcase
    end
    r.program_counter = cpu_pc;
    r.accumulator_a = cpu_a;
    r.accumulator_b = cpu_b;
    r.awaiting_input = cpu_wait;
    core_after_q.push_back(r);
    return ignored;
  endfunction

  function automatic void send(in_t rq);
    if (!advance_core(rq)) useful_n++;
    request_q.push_back(rq);
  endfunction

  function automatic void send_load(logic [31:0] addr, logic [31:0] data);
    in_t rq;
    logic [31:0] idx;
    idx = word_of(addr);
    rq = '0;
    rq.kind = K_LOAD;
    rq.word_address = idx[15:0];
    rq.word_data = data;
    rq.reply_byte = 8'($urandom);
    send(rq);
  endfunction

  function automatic void send_other(logic [1:0] kind, logic [15:0] addr, logic [7:0] rbyte);
    in_t rq;
    rq.kind = kind;
    rq.word_address = addr;
    rq.word_data = $urandom;
    rq.reply_byte = rbyte;
    send(rq);
  endfunction

  // memory that a step is about to read gets defined first
  function automatic void need_word(logic [31:0] addr);
    if (!shadow_mem.exists(word_of(addr))) send_load(addr, $urandom);
  endfunction

  function automatic void plan_step();
    logic [31:0] w, opnd, sp;
    logic [7:0]  ib;
    if (!cpu_wait) begin
      need_word(cpu_pc >> 2);
      w = mem_get(cpu_pc >> 2) >> {cpu_pc[1:0], 3'b000};
      ib = w[7:0];
      opnd = cpu_opnd | {28'd0, ib[3:0]};
      case (ib[7:4])
        OP_LDAM, OP_LDBM: need_word(opnd);
        OP_LDAI: need_word(cpu_a + opnd);
        OP_LDBI: need_word(cpu_b + opnd);
        OP_OPR: begin
          if (opnd == OPR_SVC) begin
            need_word(SP_WORD);
            sp = mem_get(SP_WORD);
            if (cpu_a == SVC_OUT || cpu_a == SVC_IN) need_word(sp + 32'd2);
            if (cpu_a == SVC_OUT) need_word(sp + 32'd3);
          end
        end
        default: ;
      endcase
    end
    send_other(K_STEP, 16'($urandom), 8'($urandom));
  endfunction

  // patch instruction bytes in at pc, then run through them
  function automatic void run_code(logic [7:0] code[$]);
    logic [31:0] addr, w;
    addr = cpu_pc;
    w = '0;
    for (int i = 0; i < code.size(); i++) begin
      if (i == 0 || addr[1:0] == 2'd0) begin
        w = shadow_mem.exists(word_of(addr >> 2)) ? mem_get(addr >> 2) : $urandom;
      end
      w[{addr[1:0], 3'b000} +: 8] = code[i];
      if (i == code.size() - 1 || addr[1:0] == 2'd3) send_load(addr >> 2, w);
      addr = addr + 32'd1;
    end
    for (int i = 0; i < code.size(); i++) plan_step();
  endfunction

  function automatic void call_service(logic [3:0] svc, logic [31:0] sp, logic [31:0] arg,
                                       logic [31:0] sel);
    logic [7:0] code[$];
    send_load(SP_WORD, sp);
    send_load(sp + 32'd2, arg);
    send_load(sp + 32'd3, sel);
    // clear a leftover prefix so the constant load gives the call number
    if (cpu_opnd != 32'd0) code.push_back({OP_LDBC, 4'h0});
    code.push_back({OP_LDAC, svc});
    code.push_back({OP_OPR, OPR_SVC[3:0]});
    run_code(code);
  endfunction

  function automatic logic [7:0] pick_instruction();
    logic [3:0] op;
    op = 4'($urandom);
    if (op == OP_OPR && $urandom_range(0, 3) != 0) return {op, 2'b00, 2'($urandom)};
    return {op, 4'($urandom)};
  endfunction

  function automatic logic [31:0] pick_selector();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 255);
      1: return {1'b1, 31'($urandom)};
      2: return $urandom_range(256, 2047);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_stack();
    if ($urandom_range(0, 1) == 0) return $urandom_range(8, 16'hFFF0);
    return $urandom;
  endfunction

  function automatic int unsigned pick_wait(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) quiet = $urandom_range(10, 60);
    return $urandom_range(0, 12);
  endfunction

  function automatic int field_bad(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v === got_v) return 0;
    $error("%s: expected %0h, got %0h", name, exp_v, got_v);
    return 1;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    in_t  np;
    int unsigned wn;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      in_wait <= 0;
    end else begin
      nv = in_if.valid;
      np = in_if.payload;
      wn = in_wait;
      if (in_if.valid && in_if.ready) begin
        nv = 1'b0;
        wn = pick_wait(in_quiet);
      end
      if (!nv) begin
        if (wn > 0) begin
          wn--;
        end else if (request_q.size() > 0) begin
          nv = 1'b1;
          np = request_q.pop_front();
        end
      end
      in_if.valid <= nv;
      in_if.payload <= np;
      in_wait <= wn;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r, got_r;
    int unsigned wn;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      wn = out_wait;
      if (out_if.valid && out_if.ready) begin
        got_r = out_if.payload;
        if (core_after_q.size() == 0) begin
          $error("result with no request outstanding");
          err_n++;
        end else begin
          exp_r = core_after_q.pop_front();
          err_n += field_bad("program_counter", exp_r.program_counter, got_r.program_counter);
          err_n += field_bad("accumulator_a", exp_r.accumulator_a, got_r.accumulator_a);
          err_n += field_bad("accumulator_b", exp_r.accumulator_b, got_r.accumulator_b);
          err_n += field_bad("fetched_byte", 32'(exp_r.fetched_byte),
                             32'(got_r.fetched_byte));
          err_n += field_bad("service_event", 32'(exp_r.service_event),
                             32'(got_r.service_event));
          err_n += field_bad("io_channel", 32'(exp_r.io_channel), 32'(got_r.io_channel));
          err_n += field_bad("output_byte", 32'(exp_r.output_byte), 32'(got_r.output_byte));
          err_n += field_bad("read_word", exp_r.read_word, got_r.read_word);
          err_n += field_bad("awaiting_input", 32'(exp_r.awaiting_input),
                             32'(got_r.awaiting_input));
        end
        wn = pick_wait(out_quiet);
      end
      if (wn > 0) begin
        out_if.ready <= 1'b0;
        out_wait <= wn - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  // no request or result moving for too long means the core hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("prefix_instruction_cpu_core_unit_tb NOT OK");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] code[$];
    int unsigned pick, n;
    cpu_pc = '0;
    cpu_a = '0;
    cpu_b = '0;
    cpu_opnd = '0;
    cpu_wait = 1'b0;
    reply_at = '0;
    useful_n = 0;

    // directed: address and data extremes, the service calls, ignored requests
    send_load(32'hFFFF, 32'hFFFF_FFFF);
    send_other(K_READ, 16'hFFFF, 8'h00);
    code = '{{OP_BR, 4'h7}};   // hop over the stack pointer word
    run_code(code);
    call_service(SVC_OUT[3:0], 32'h0000_2000, 32'h0000_01A5, 32'h0000_07FF);
    call_service(SVC_IN[3:0], 32'h0000_3000, 32'h0000_0100, 32'h0);
    send_other(K_STEP, 16'h0, 8'h00);
    send_other(K_REPLY, 16'h0, 8'hFF);
    send_other(K_REPLY, 16'hFFFF, 8'h00);
    code = '{{OP_NFIX, 4'h1}, {OP_PFIX, 4'hF}, {OP_LDAC, 4'hF}, {OP_NOP, 4'h5},
             {OP_OPR, 4'h7}, {OP_LDAC, 4'h0}, {OP_OPR, OPR_SVC[3:0]}};
    run_code(code);

    while (useful_n < ITEMS) begin
      if (cpu_wait) begin
        case ($urandom_range(0, 9))
          0: send_other(K_STEP, 16'($urandom), 8'($urandom));
          1: send_load($urandom, $urandom);
          2: send_other(K_READ, written_q[$urandom_range(0, written_q.size() - 1)],
                        8'($urandom));
          default: send_other(K_REPLY, 16'($urandom), 8'($urandom));
        endcase
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          code = {};
          n = $urandom_range(1, 6);
          repeat (n) code.push_back(pick_instruction());
          run_code(code);
        end else if (pick < 45) begin
          repeat ($urandom_range(1, 4)) plan_step();
        end else if (pick < 65) begin
          case ($urandom_range(0, 4))
            0: call_service(SVC_EXIT[3:0], pick_stack(), $urandom, $urandom);
            1, 2: call_service(SVC_OUT[3:0], pick_stack(), $urandom, pick_selector());
            default: call_service(SVC_IN[3:0], pick_stack(), pick_selector(), $urandom);
          endcase
        end else if (pick < 77) begin
          code = {};
          repeat ($urandom_range(0, 3)) begin
            code.push_back({($urandom_range(0, 1) != 0) ? OP_PFIX : OP_NFIX, 4'($urandom)});
          end
          code.push_back({OP_LDAC, 4'($urandom)});
          code.push_back({OP_LDBC, 4'($urandom)});
          code.push_back({OP_OPR, 2'b00, 2'($urandom_range(0, 1))});
          if ($urandom_range(0, 2) == 0) code.push_back({OP_BRZ + 4'($urandom_range(0, 1)),
                                                        4'($urandom)});
          run_code(code);
        end else if (pick < 87) begin
          case ($urandom_range(0, 3))
            0: send_load($urandom, 32'h0);
            1: send_load($urandom, 32'hFFFF_FFFF);
            default: send_load($urandom, $urandom);
          endcase
        end else if (pick < 95) begin
          send_other(K_READ, written_q[$urandom_range(0, written_q.size() - 1)],
                     8'($urandom));
        end else begin
          send_other(K_REPLY, 16'($urandom), 8'($urandom));
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_if.valid || core_after_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (err_n == 0 && core_after_q.size() == 0) begin
      $display("prefix_instruction_cpu_core_unit_tb OK");
    end else begin
      $display("prefix_instruction_cpu_core_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
